[design/circle_elastic_collision_resolve_top_macros.svh]
// Assertion macros shared by the collision resolver RTL.
`ifndef CIRCLE_ELASTIC_COLLISION_RESOLVE_TOP_MACROS_SVH
`define CIRCLE_ELASTIC_COLLISION_RESOLVE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define ECR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, clocked on clk, off during reset
`define ECR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ECR_ASSERT_IMP(lbl, ante, cons, msg)
`define ECR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[design/ecr_pkg.sv]
// Shared constants and types of the circle collision resolver.
`default_nettype none
package ecr_pkg;
  // fraction bits of the unit normal (Q2.30)
  localparam int NORM_BITS   = 30;
  // pipelined square root and divider depths, one result bit per stage
  localparam int SQRT_STAGES = 32;
  localparam int QUO_W       = 32;
  localparam int NUM_W       = 2 * QUO_W;
  localparam int DIV_STAGES  = QUO_W;

  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_RESOLVED = 2'd1,
    STAT_COINCIDE = 2'd2
  } status_t;
endpackage
`default_nettype wire

[design/ecr_delay.sv]
// Stall-aware delay line carrying a valid bit with its payload.
`default_nettype none
module ecr_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  output logic [W-1:0]      out_data
);
  logic [W-1:0] data_r  [1:DEPTH];
  logic         valid_r [1:DEPTH];

  genvar k;
  generate
    for (k = 1; k <= DEPTH; k++) begin : g_tap
      logic [W-1:0] prev_data;
      logic         prev_valid;
      if (k == 1) begin : g_first
        assign prev_data  = in_data;
        assign prev_valid = in_valid;
      end else begin : g_rest
        assign prev_data  = data_r[k-1];
        assign prev_valid = valid_r[k-1];
      end
      // valid bits are control state and reset; payload is not
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (en) begin
          valid_r[k] <= prev_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          data_r[k] <= prev_data;
        end
      end
    end
  endgenerate

  assign out_valid = valid_r[DEPTH];
  assign out_data  = data_r[DEPTH];
endmodule
`default_nettype wire

[design/ecr_sqrt_pipe.sv]
// Pipelined 64-bit integer square root, one root bit per stage.
`default_nettype none
module ecr_sqrt_pipe (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad,
  output logic [31:0]      root
);
  localparam int N = ecr_pkg::SQRT_STAGES;

  logic [63:0] v_r   [1:N];
  logic [63:0] res_r [1:N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] cur_v, cur_res, trial;
      logic        ge;
      if (k == 0) begin : g_first
        assign cur_v   = rad;
        assign cur_res = '0;
      end else begin : g_rest
        assign cur_v   = v_r[k];
        assign cur_res = res_r[k];
      end
      // digit recurrence: try the next root bit
      assign trial = cur_res + BIT;
      assign ge    = (cur_v >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[k+1]   <= ge ? (cur_v - trial) : cur_v;
          res_r[k+1] <= ge ? ((cur_res >> 1) + BIT) : (cur_res >> 1);
        end
      end
    end
  endgenerate

  assign root = res_r[N][31:0];
endmodule
`default_nettype wire

[design/ecr_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module ecr_div_pipe (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ecr_pkg::NUM_W-1:0]  num,
  input  wire logic [ecr_pkg::QUO_W-1:0]  den,
  output logic [ecr_pkg::QUO_W-1:0]       quo
);
  localparam int W = ecr_pkg::QUO_W;
  localparam int N = ecr_pkg::DIV_STAGES;

  // upper half of num must stay below den for the quotient to fit
  logic [W-1:0] rem_r [1:N];
  logic [W-1:0] low_r [1:N];
  logic [W-1:0] q_r   [1:N];
  logic [W-1:0] den_r [1:N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [W-1:0] cur_rem, cur_low, cur_q, cur_den;
      logic [W:0]   t, diff;
      logic         ge;
      if (k == 0) begin : g_first
        assign cur_rem = num[2*W-1:W];
        assign cur_low = num[W-1:0];
        assign cur_q   = '0;
        assign cur_den = den;
      end else begin : g_rest
        assign cur_rem = rem_r[k];
        assign cur_low = low_r[k];
        assign cur_q   = q_r[k];
        assign cur_den = den_r[k];
      end
      // shift in the next dividend bit, subtract when it fits
      assign t    = {cur_rem, cur_low[W-1]};
      assign diff = t - {1'b0, cur_den};
      assign ge   = (t >= {1'b0, cur_den});
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? diff[W-1:0] : t[W-1:0];
          low_r[k+1] <= {cur_low[W-2:0], 1'b0};
          q_r[k+1]   <= {cur_q[W-2:0], ge};
          den_r[k+1] <= cur_den;
        end
      end
    end
  endgenerate

  assign quo = q_r[N];
endmodule
`default_nettype wire

[design/circle_elastic_collision_resolve_top.sv]
// Top level of the two-circle elastic collision resolver pipeline.
// Usage:
//   One beat on the in_ channel carries a pair of circles (center, velocity,
//   radius, Q16.16). One beat on the out_ channel carries the resolved pair and
//   contact_status (0 no contact, 1 resolved, 2 centers coincide).
//   A beat moves when valid is high and stall is low at a rising clock edge.
//   Throughput: one pair per cycle while in_stall is low, with no dependency between pairs.
//   Pipeline: the 32-stage square root and the 32-stage divider bank, each
//   producing one bit per stage, plus 15 arithmetic and register stages
//   around them.
//   Stall: the output register is backed by a one-beat skid buffer. When the
//   receiver stalls, the pipeline keeps moving until the skid fills; then the
//   whole pipeline freezes and in_stall is raised. Nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits and the skid buffer;
//   the block accepts beats from the first cycle after reset.
`default_nettype none
`include "circle_elastic_collision_resolve_top_macros.svh"
module circle_elastic_collision_resolve_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_first_pos_x,
  input  wire logic signed [31:0] in_first_pos_y,
  input  wire logic signed [31:0] in_first_vel_x,
  input  wire logic signed [31:0] in_first_vel_y,
  input  wire logic        [30:0] in_first_radius,
  input  wire logic signed [31:0] in_second_pos_x,
  input  wire logic signed [31:0] in_second_pos_y,
  input  wire logic signed [31:0] in_second_vel_x,
  input  wire logic signed [31:0] in_second_vel_y,
  input  wire logic        [30:0] in_second_radius,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_new_first_pos_x,
  output logic signed [31:0]      out_new_first_pos_y,
  output logic signed [31:0]      out_new_first_vel_x,
  output logic signed [31:0]      out_new_first_vel_y,
  output logic signed [31:0]      out_new_second_pos_x,
  output logic signed [31:0]      out_new_second_pos_y,
  output logic signed [31:0]      out_new_second_vel_x,
  output logic signed [31:0]      out_new_second_vel_y,
  output logic [1:0]              out_contact_status
);
  localparam int NB = ecr_pkg::NORM_BITS;

  typedef struct packed {
    logic signed [31:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
    logic [30:0]        ra, rb;
  } circ_t;

  typedef struct packed {
    circ_t              c;
    logic [31:0]        r;
    logic [31:0]        ux, uy;
    logic               dx_neg, dy_neg;
    logic [31:0]        rvx_mag, rvy_mag;
    logic               rvx_neg, rvy_neg;
    ecr_pkg::status_t   status;
  } side_t;

  typedef struct packed {
    circ_t              c;
    logic               dx_neg, dy_neg;
    ecr_pkg::status_t   status;
    logic signed [35:0] fpx, fpy, spx, spy;
  } keep_t;

  typedef struct packed {
    side_t       side;
    logic [62:0] pxa, pya, pxb, pyb, tx, ty;
    logic [31:0] ka, kb;
    logic [30:0] nx, ny;
  } m1_t;

  typedef struct packed {
    keep_t              k;
    logic signed [64:0] dot;
    logic [31:0]        ka, kb;
    logic [30:0]        nx, ny;
  } m2_t;

  typedef struct packed {
    keep_t       k;
    logic [33:0] rel;
    logic        rel_neg;
    logic [31:0] ka, kb;
    logic [30:0] nx, ny;
  } m3_t;

  typedef struct packed {
    keep_t       k;
    logic        rel_neg;
    logic [63:0] pla, plb;
    logic [33:0] pha, phb;
    logic [30:0] nx, ny;
  } m4_t;

  typedef struct packed {
    keep_t       k;
    logic        rel_neg;
    logic [35:0] da, db;
    logic [30:0] nx, ny;
  } m5_t;

  typedef struct packed {
    keep_t       k;
    logic        rel_neg;
    logic [62:0] lxa, lya, lxb, lyb;
    logic [34:0] hxa, hya, hxb, hyb;
  } m6_t;

  typedef struct packed {
    keep_t       k;
    logic        rel_neg;
    logic [37:0] mxa, mya, mxb, myb;
  } m7_t;

  typedef struct packed {
    logic signed [31:0] fpx, fpy, fvx, fvy, spx, spy, svx, svy;
    ecr_pkg::status_t   status;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] s;
    if (v[39] == 1'b0 && v[38:31] != 8'h00) begin
      s = 32'sh7FFF_FFFF;
    end else if (v[39] == 1'b1 && v[38:31] != 8'hFF) begin
      s = -32'sh8000_0000;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

  // pipeline advances unless the skid buffer holds a beat
  logic en;
  logic skid_full_r, out_valid_r;
  out_t out_r, skid_r;
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  // stage registers
  circ_t       s0_r;
  side_t       s1_r, s1_nxt, s2_r, s3_r, s3_nxt;
  logic [63:0] sx_r, sy_r, rr_r, d2_r;
  logic        s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  side_t       sq_side, p1_r, p2_r, dv_side;
  logic        sq_v, p1_v_r, p2_v_r, dv_v;
  logic [31:0] sq_root, pen_r, dist_r, p2_dist_r;
  logic [62:0] pa_r, pb_r;
  logic [31:0] q_nx, q_ny, q_sa, q_sb, q_ka, q_kb;
  m1_t m1_r, m1_nxt;
  m2_t m2_r, m2_nxt;
  m3_t m3_r, m3_nxt;
  m4_t m4_r, m4_nxt;
  m5_t m5_r, m5_nxt;
  m6_t m6_r, m6_nxt;
  m7_t m7_r, m7_nxt;
  out_t m8_r, m8_nxt;
  logic m1_v_r, m2_v_r, m3_v_r, m4_v_r, m5_v_r, m6_v_r, m7_v_r, m8_v_r;

  // S1: differences, magnitudes and radius sum
  always_comb begin
    logic signed [32:0] dx, dy, rvx, rvy;
    logic [32:0] ax, ay, arx, ary;
    dx  = {s0_r.bpx[31], s0_r.bpx} - {s0_r.apx[31], s0_r.apx};
    dy  = {s0_r.bpy[31], s0_r.bpy} - {s0_r.apy[31], s0_r.apy};
    rvx = {s0_r.bvx[31], s0_r.bvx} - {s0_r.avx[31], s0_r.avx};
    rvy = {s0_r.bvy[31], s0_r.bvy} - {s0_r.avy[31], s0_r.avy};
    ax  = dx[32]  ? -dx  : dx;
    ay  = dy[32]  ? -dy  : dy;
    arx = rvx[32] ? -rvx : rvx;
    ary = rvy[32] ? -rvy : rvy;
    s1_nxt.c       = s0_r;
    s1_nxt.r       = {1'b0, s0_r.ra} + {1'b0, s0_r.rb};
    s1_nxt.ux      = ax[31:0];
    s1_nxt.uy      = ay[31:0];
    s1_nxt.dx_neg  = dx[32];
    s1_nxt.dy_neg  = dy[32];
    s1_nxt.rvx_mag = arx[31:0];
    s1_nxt.rvy_mag = ary[31:0];
    s1_nxt.rvx_neg = rvx[32];
    s1_nxt.rvy_neg = rvy[32];
    s1_nxt.status  = ecr_pkg::STAT_NONE;
  end

  // S3: squared distance against squared radius sum, and coincident centers
  always_comb begin
    logic [64:0] sum;
    sum    = {1'b0, sx_r} + {1'b0, sy_r};
    s3_nxt = s2_r;
    if (sum[64] || (sum[63:0] > rr_r)) begin
      s3_nxt.status = ecr_pkg::STAT_NONE;
    end else if (s2_r.ux == '0 && s2_r.uy == '0) begin
      s3_nxt.status = ecr_pkg::STAT_COINCIDE;
    end else begin
      s3_nxt.status = ecr_pkg::STAT_RESOLVED;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= '{apx: in_first_pos_x,  apy: in_first_pos_y,
                avx: in_first_vel_x,  avy: in_first_vel_y,
                bpx: in_second_pos_x, bpy: in_second_pos_y,
                bvx: in_second_vel_x, bvy: in_second_vel_y,
                ra: in_first_radius,  rb: in_second_radius};
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      sx_r <= s1_r.ux * s1_r.ux;
      sy_r <= s1_r.uy * s1_r.uy;
      rr_r <= s1_r.r * s1_r.r;
      s3_r <= s3_nxt;
      d2_r <= {sx_r + sy_r};
    end
  end

  // square root of the squared distance, side data alongside
  ecr_sqrt_pipe u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (d2_r),
    .root (sq_root)
  );

  ecr_delay #(.W($bits(side_t)), .DEPTH(ecr_pkg::SQRT_STAGES)) u_dly_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_data   (s3_r),
    .out_valid (sq_v),
    .out_data  (sq_side)
  );

  // P1: penetration depth; P2: weighted push numerators
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r      <= sq_side;
      pen_r     <= sq_side.r - sq_root;
      dist_r    <= sq_root;
      p2_r      <= p1_r;
      p2_dist_r <= dist_r;
      pa_r      <= pen_r * p1_r.c.rb;
      pb_r      <= pen_r * p1_r.c.ra;
    end
  end

  // divider bank: normal, push distances, velocity weights
  ecr_div_pipe u_div_nx (
    .clk (clk), .en (en),
    .num ({2'b00, p2_r.ux, {NB{1'b0}}}), .den (p2_dist_r), .quo (q_nx)
  );
  ecr_div_pipe u_div_ny (
    .clk (clk), .en (en),
    .num ({2'b00, p2_r.uy, {NB{1'b0}}}), .den (p2_dist_r), .quo (q_ny)
  );
  ecr_div_pipe u_div_sa (
    .clk (clk), .en (en),
    .num ({1'b0, pa_r}), .den (p2_r.r), .quo (q_sa)
  );
  ecr_div_pipe u_div_sb (
    .clk (clk), .en (en),
    .num ({1'b0, pb_r}), .den (p2_r.r), .quo (q_sb)
  );
  ecr_div_pipe u_div_ka (
    .clk (clk), .en (en),
    .num ({2'b00, p2_r.c.rb, {(NB + 1){1'b0}}}), .den (p2_r.r), .quo (q_ka)
  );
  ecr_div_pipe u_div_kb (
    .clk (clk), .en (en),
    .num ({2'b00, p2_r.c.ra, {(NB + 1){1'b0}}}), .den (p2_r.r), .quo (q_kb)
  );

  ecr_delay #(.W($bits(side_t)), .DEPTH(ecr_pkg::DIV_STAGES)) u_dly_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p2_v_r),
    .in_data   (p2_r),
    .out_valid (dv_v),
    .out_data  (dv_side)
  );

  // M1: push and dot-product partial products
  always_comb begin
    m1_nxt.side = dv_side;
    m1_nxt.nx   = q_nx[30:0];
    m1_nxt.ny   = q_ny[30:0];
    m1_nxt.ka   = q_ka;
    m1_nxt.kb   = q_kb;
    m1_nxt.pxa  = q_nx[30:0] * q_sa;
    m1_nxt.pya  = q_ny[30:0] * q_sa;
    m1_nxt.pxb  = q_nx[30:0] * q_sb;
    m1_nxt.pyb  = q_ny[30:0] * q_sb;
    m1_nxt.tx   = dv_side.rvx_mag * q_nx[30:0];
    m1_nxt.ty   = dv_side.rvy_mag * q_ny[30:0];
  end

  // M2: new positions and signed dot product
  always_comb begin
    logic signed [35:0] ax, ay, bx, by, mxa, mya, mxb, myb;
    logic signed [64:0] tx, ty;
    ax  = {{4{m1_r.side.c.apx[31]}}, m1_r.side.c.apx};
    ay  = {{4{m1_r.side.c.apy[31]}}, m1_r.side.c.apy};
    bx  = {{4{m1_r.side.c.bpx[31]}}, m1_r.side.c.bpx};
    by  = {{4{m1_r.side.c.bpy[31]}}, m1_r.side.c.bpy};
    mxa = {3'b000, m1_r.pxa[62:NB]};
    mya = {3'b000, m1_r.pya[62:NB]};
    mxb = {3'b000, m1_r.pxb[62:NB]};
    myb = {3'b000, m1_r.pyb[62:NB]};
    tx  = {2'b00, m1_r.tx};
    ty  = {2'b00, m1_r.ty};
    m2_nxt.k.c      = m1_r.side.c;
    m2_nxt.k.dx_neg = m1_r.side.dx_neg;
    m2_nxt.k.dy_neg = m1_r.side.dy_neg;
    m2_nxt.k.status = m1_r.side.status;
    m2_nxt.k.fpx    = m1_r.side.dx_neg ? (ax + mxa) : (ax - mxa);
    m2_nxt.k.fpy    = m1_r.side.dy_neg ? (ay + mya) : (ay - mya);
    m2_nxt.k.spx    = m1_r.side.dx_neg ? (bx - mxb) : (bx + mxb);
    m2_nxt.k.spy    = m1_r.side.dy_neg ? (by - myb) : (by + myb);
    m2_nxt.dot      = ((m1_r.side.rvx_neg ^ m1_r.side.dx_neg) ? -tx : tx)
                    + ((m1_r.side.rvy_neg ^ m1_r.side.dy_neg) ? -ty : ty);
    m2_nxt.ka       = m1_r.ka;
    m2_nxt.kb       = m1_r.kb;
    m2_nxt.nx       = m1_r.nx;
    m2_nxt.ny       = m1_r.ny;
  end

  // M3: normal relative speed, truncated toward zero
  always_comb begin
    logic [64:0] mag;
    mag            = m2_r.dot[64] ? -m2_r.dot : m2_r.dot;
    m3_nxt.k       = m2_r.k;
    m3_nxt.rel     = mag[63:NB];
    m3_nxt.rel_neg = m2_r.dot[64];
    m3_nxt.ka      = m2_r.ka;
    m3_nxt.kb      = m2_r.kb;
    m3_nxt.nx      = m2_r.nx;
    m3_nxt.ny      = m2_r.ny;
  end

  // M4: speed times mass weight, split into two partial products
  always_comb begin
    m4_nxt.k       = m3_r.k;
    m4_nxt.rel_neg = m3_r.rel_neg;
    m4_nxt.pla     = m3_r.rel[31:0] * m3_r.ka;
    m4_nxt.plb     = m3_r.rel[31:0] * m3_r.kb;
    m4_nxt.pha     = m3_r.rel[33:32] * m3_r.ka;
    m4_nxt.phb     = m3_r.rel[33:32] * m3_r.kb;
    m4_nxt.nx      = m3_r.nx;
    m4_nxt.ny      = m3_r.ny;
  end

  // M5: combine partials into the velocity change magnitudes
  always_comb begin
    logic [65:0] sa, sb;
    sa             = {2'b00, m4_r.pla} + {m4_r.pha, 32'h0};
    sb             = {2'b00, m4_r.plb} + {m4_r.phb, 32'h0};
    m5_nxt.k       = m4_r.k;
    m5_nxt.rel_neg = m4_r.rel_neg;
    m5_nxt.da      = sa[65:NB];
    m5_nxt.db      = sb[65:NB];
    m5_nxt.nx      = m4_r.nx;
    m5_nxt.ny      = m4_r.ny;
  end

  // M6: project the change onto the normal, partial products
  always_comb begin
    m6_nxt.k       = m5_r.k;
    m6_nxt.rel_neg = m5_r.rel_neg;
    m6_nxt.lxa     = m5_r.nx * m5_r.da[31:0];
    m6_nxt.lya     = m5_r.ny * m5_r.da[31:0];
    m6_nxt.lxb     = m5_r.nx * m5_r.db[31:0];
    m6_nxt.lyb     = m5_r.ny * m5_r.db[31:0];
    m6_nxt.hxa     = m5_r.nx * m5_r.da[35:32];
    m6_nxt.hya     = m5_r.ny * m5_r.da[35:32];
    m6_nxt.hxb     = m5_r.nx * m5_r.db[35:32];
    m6_nxt.hyb     = m5_r.ny * m5_r.db[35:32];
  end

  // M7: combine projection partials
  always_comb begin
    logic [67:0] xa, ya, xb, yb;
    xa             = {5'b00000, m6_r.lxa} + {1'b0, m6_r.hxa, 32'h0};
    ya             = {5'b00000, m6_r.lya} + {1'b0, m6_r.hya, 32'h0};
    xb             = {5'b00000, m6_r.lxb} + {1'b0, m6_r.hxb, 32'h0};
    yb             = {5'b00000, m6_r.lyb} + {1'b0, m6_r.hyb, 32'h0};
    m7_nxt.k       = m6_r.k;
    m7_nxt.rel_neg = m6_r.rel_neg;
    m7_nxt.mxa     = xa[67:NB];
    m7_nxt.mya     = ya[67:NB];
    m7_nxt.mxb     = xb[67:NB];
    m7_nxt.myb     = yb[67:NB];
  end

  // M8: apply velocity changes, saturate, pick pass-through unless resolved
  always_comb begin
    logic signed [39:0] vax, vay, vbx, vby, mxa, mya, mxb, myb;
    logic               nxa, nya, nxb, nyb;
    vax = {{8{m7_r.k.c.avx[31]}}, m7_r.k.c.avx};
    vay = {{8{m7_r.k.c.avy[31]}}, m7_r.k.c.avy};
    vbx = {{8{m7_r.k.c.bvx[31]}}, m7_r.k.c.bvx};
    vby = {{8{m7_r.k.c.bvy[31]}}, m7_r.k.c.bvy};
    mxa = {2'b00, m7_r.mxa};
    mya = {2'b00, m7_r.mya};
    mxb = {2'b00, m7_r.mxb};
    myb = {2'b00, m7_r.myb};
    // second circle's change carries the opposite sign of the first
    nxa = m7_r.k.dx_neg ^ m7_r.rel_neg;
    nya = m7_r.k.dy_neg ^ m7_r.rel_neg;
    nxb = m7_r.k.dx_neg ^ !m7_r.rel_neg;
    nyb = m7_r.k.dy_neg ^ !m7_r.rel_neg;
    m8_nxt.status = m7_r.k.status;
    if (m7_r.k.status == ecr_pkg::STAT_RESOLVED) begin
      m8_nxt.fpx = sat32({{4{m7_r.k.fpx[35]}}, m7_r.k.fpx});
      m8_nxt.fpy = sat32({{4{m7_r.k.fpy[35]}}, m7_r.k.fpy});
      m8_nxt.spx = sat32({{4{m7_r.k.spx[35]}}, m7_r.k.spx});
      m8_nxt.spy = sat32({{4{m7_r.k.spy[35]}}, m7_r.k.spy});
      m8_nxt.fvx = sat32(nxa ? (vax - mxa) : (vax + mxa));
      m8_nxt.fvy = sat32(nya ? (vay - mya) : (vay + mya));
      m8_nxt.svx = sat32(nxb ? (vbx - mxb) : (vbx + mxb));
      m8_nxt.svy = sat32(nyb ? (vby - myb) : (vby + myb));
    end else begin
      m8_nxt.fpx = m7_r.k.c.apx;
      m8_nxt.fpy = m7_r.k.c.apy;
      m8_nxt.spx = m7_r.k.c.bpx;
      m8_nxt.spy = m7_r.k.c.bpy;
      m8_nxt.fvx = m7_r.k.c.avx;
      m8_nxt.fvy = m7_r.k.c.avy;
      m8_nxt.svx = m7_r.k.c.bvx;
      m8_nxt.svy = m7_r.k.c.bvy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
      m4_r <= m4_nxt;
      m5_r <= m5_nxt;
      m6_r <= m6_nxt;
      m7_r <= m7_nxt;
      m8_r <= m8_nxt;
    end
  end

  // valid bits of the explicit stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0; s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0;
      p1_v_r <= 1'b0; p2_v_r <= 1'b0;
      m1_v_r <= 1'b0; m2_v_r <= 1'b0; m3_v_r <= 1'b0; m4_v_r <= 1'b0;
      m5_v_r <= 1'b0; m6_v_r <= 1'b0; m7_v_r <= 1'b0; m8_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid; s1_v_r <= s0_v_r; s2_v_r <= s1_v_r; s3_v_r <= s2_v_r;
      p1_v_r <= sq_v;     p2_v_r <= p1_v_r;
      m1_v_r <= dv_v;     m2_v_r <= m1_v_r; m3_v_r <= m2_v_r; m4_v_r <= m3_v_r;
      m5_v_r <= m4_v_r;   m6_v_r <= m5_v_r; m7_v_r <= m6_v_r; m8_v_r <= m7_v_r;
    end
  end

  // output register with one-beat skid buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (!out_stall) begin
        out_r       <= skid_r;
        skid_full_r <= 1'b0;
      end
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= m8_v_r;
      out_r       <= m8_r;
    end else if (m8_v_r) begin
      skid_r      <= m8_r;
      skid_full_r <= 1'b1;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_new_first_pos_x  = out_r.fpx;
  assign out_new_first_pos_y  = out_r.fpy;
  assign out_new_first_vel_x  = out_r.fvx;
  assign out_new_first_vel_y  = out_r.fvy;
  assign out_new_second_pos_x = out_r.spx;
  assign out_new_second_pos_y = out_r.spy;
  assign out_new_second_vel_x = out_r.svx;
  assign out_new_second_vel_y = out_r.svy;
  assign out_contact_status   = out_r.status;

  // skid holds a beat only behind a held output beat
  `ECR_ASSERT_IMP(a_skid_behind_out, skid_full_r, out_valid_r, "skid full without output beat")
  // a beat arriving at a stalled output must land in the skid
  `ECR_ASSERT_NXT(a_skid_catch, out_valid_r && out_stall && !skid_full_r && m8_v_r,
    skid_full_r, "beat dropped at stalled output")
  // output drains when taken with nothing behind it
  `ECR_ASSERT_NXT(a_out_drain, out_valid_r && !out_stall && !skid_full_r && !m8_v_r,
    !out_valid_r, "output beat repeated")
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the two-circle elastic collision resolver.
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic signed [31:0] apx, apy, avx, avy;
    logic [30:0]        ra;
    logic signed [31:0] bpx, bpy, bvx, bvy;
    logic [30:0]        rb;
    bit                 drain_first;
  } pair_t;

  typedef struct {
    logic signed [31:0] v [8];
    ecr_pkg::status_t   status;
  } resolved_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM       = 700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_first_pos_x = '0, in_first_pos_y = '0;
  logic signed [31:0] in_first_vel_x = '0, in_first_vel_y = '0;
  logic [30:0]        in_first_radius = '0;
  logic signed [31:0] in_second_pos_x = '0, in_second_pos_y = '0;
  logic signed [31:0] in_second_vel_x = '0, in_second_vel_y = '0;
  logic [30:0]        in_second_radius = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] out_new_first_pos_x, out_new_first_pos_y;
  logic signed [31:0] out_new_first_vel_x, out_new_first_vel_y;
  logic signed [31:0] out_new_second_pos_x, out_new_second_pos_y;
  logic signed [31:0] out_new_second_vel_x, out_new_second_vel_y;
  logic [1:0]         out_contact_status;

  circle_elastic_collision_resolve_top u_top (.*);

  // clock, period 4 ns
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pair_t     pending_pairs [$];
  resolved_t expected_pairs [$];
  pair_t     cur_pair;
  bit        have_pair = 0;
  bit        in_beat = 0, out_beat = 0;
  int        send_gap = 0, recv_gap = 0, hold_cycles = 0;
  int        n_in = 0, n_out = 0, errors = 0, idle_cycles = 0;
  bit        hold_done = 0, stim_done = 0;

  // ---------------- collision predictor ----------------
  function automatic longint unsigned magn(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint scaled(longint v, longint unsigned k, int sh);
    longint unsigned m;
    m = (magn(v) * k) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic resolved_t resolve_pair(pair_t p);
    resolved_t res;
    longint apx, apy, avx, avy, bpx, bpy, bvx, bvy, dx, dy, nx, ny;
    longint rvx, rvy, dot, rel, da, db;
    longint r_out [8];
    longint unsigned ra, rb, ux, uy, rsum, sx, sy, d2, dlen, pen;
    longint unsigned sa, sb, ka, kb;
    apx = p.apx; apy = p.apy; avx = p.avx; avy = p.avy;
    bpx = p.bpx; bpy = p.bpy; bvx = p.bvx; bvy = p.bvy;
    ra = p.ra; rb = p.rb;
    r_out = '{apx, apy, avx, avy, bpx, bpy, bvx, bvy};
    dx = bpx - apx; dy = bpy - apy;
    ux = magn(dx); uy = magn(dy);
    rsum = ra + rb;
    sx = ux * ux; sy = uy * uy;
    d2 = sx + sy;
    if (d2 < sx || d2 > rsum * rsum) begin
      res.status = ecr_pkg::STAT_NONE;
    end else if (dx == 0 && dy == 0) begin
      res.status = ecr_pkg::STAT_COINCIDE;
    end else begin
      dlen = int_sqrt(d2);
      pen = rsum - dlen;
      nx = scaled(dx, 64'd1 << ecr_pkg::NORM_BITS, 0);
      ny = scaled(dy, 64'd1 << ecr_pkg::NORM_BITS, 0);
      nx = nx < 0 ? -longint'(magn(nx) / dlen) : longint'(magn(nx) / dlen);
      ny = ny < 0 ? -longint'(magn(ny) / dlen) : longint'(magn(ny) / dlen);
      sa = pen * rb / rsum;
      sb = pen * ra / rsum;
      r_out[0] = apx - scaled(nx, sa, ecr_pkg::NORM_BITS);
      r_out[1] = apy - scaled(ny, sa, ecr_pkg::NORM_BITS);
      r_out[4] = bpx + scaled(nx, sb, ecr_pkg::NORM_BITS);
      r_out[5] = bpy + scaled(ny, sb, ecr_pkg::NORM_BITS);
      rvx = bvx - avx;
      rvy = bvy - avy;
      dot = scaled(rvx, magn(nx), 0) * (nx < 0 ? -1 : 1)
          + scaled(rvy, magn(ny), 0) * (ny < 0 ? -1 : 1);
      rel = scaled(dot, 1, ecr_pkg::NORM_BITS);
      ka = (rb << (ecr_pkg::NORM_BITS + 1)) / rsum;
      kb = (ra << (ecr_pkg::NORM_BITS + 1)) / rsum;
      da = scaled(rel, ka, ecr_pkg::NORM_BITS);
      db = -scaled(rel, kb, ecr_pkg::NORM_BITS);
      r_out[2] = avx + scaled(nx, magn(da), ecr_pkg::NORM_BITS) * (da < 0 ? -1 : 1);
      r_out[3] = avy + scaled(ny, magn(da), ecr_pkg::NORM_BITS) * (da < 0 ? -1 : 1);
      r_out[6] = bvx + scaled(nx, magn(db), ecr_pkg::NORM_BITS) * (db < 0 ? -1 : 1);
      r_out[7] = bvy + scaled(ny, magn(db), ecr_pkg::NORM_BITS) * (db < 0 ? -1 : 1);
      res.status = ecr_pkg::STAT_RESOLVED;
    end
    foreach (r_out[i]) res.v[i] = clamp32(r_out[i]);
    return res;
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic pair_t make_pair(longint apx, longint apy, longint avx, longint avy,
                                      longint ra, longint bpx, longint bpy, longint bvx,
                                      longint bvy, longint rb);
    pair_t p;
    p.apx = apx[31:0]; p.apy = apy[31:0]; p.avx = avx[31:0]; p.avy = avy[31:0];
    p.ra = ra[30:0];
    p.bpx = bpx[31:0]; p.bpy = bpy[31:0]; p.bvx = bvx[31:0]; p.bvy = bvy[31:0];
    p.rb = rb[30:0];
    p.drain_first = 0;
    return p;
  endfunction

  // signed random value of up to nb bits
  function automatic logic signed [31:0] rand_bits(int nb);
    logic [31:0] r;
    r = $urandom;
    if (nb >= 32) return r;
    return $signed(r << (32 - nb)) >>> (32 - nb);
  endfunction

  // near pair, mostly in contact, random scale
  function automatic pair_t near_pair();
    pair_t p;
    int k;
    k = $urandom_range(3, 30);
    p.apx = $urandom; p.apy = $urandom;
    p.avx = rand_bits($urandom_range(4, 32)); p.avy = rand_bits($urandom_range(4, 32));
    p.bvx = rand_bits($urandom_range(4, 32)); p.bvy = rand_bits($urandom_range(4, 32));
    p.bpx = p.apx + rand_bits(k + 1);
    p.bpy = p.apy + rand_bits(k + 1);
    p.ra = 31'($urandom & ((32'd1 << k) - 1));
    p.rb = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom & ((32'd1 << k) - 1));
    if ($urandom_range(0, 7) == 0) p.ra = 31'd0;
    p.drain_first = 0;
    return p;
  endfunction

  function automatic pair_t wild_pair();
    pair_t p;
    p.apx = $urandom; p.apy = $urandom; p.avx = $urandom; p.avy = $urandom;
    p.bpx = $urandom; p.bpy = $urandom; p.bvx = $urandom; p.bvy = $urandom;
    p.ra = 31'($urandom); p.rb = 31'($urandom);
    p.drain_first = 0;
    return p;
  endfunction

  initial begin
    pair_t p;
    longint mx, mn, rmax;
    mx = 64'sd2147483647; mn = -64'sd2147483648; rmax = 64'sd2147483647;
    // directed part
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));          // coincide, no radius
    pending_pairs.push_back(make_pair(5, 7, 1, 2, 100, 5, 7, 3, 4, 200));      // coincide
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 1, 10, 0, 0, 0, 1));         // apart
    pending_pairs.push_back(make_pair(0, 0, 65536, 0, 3, 3, 4, -65536, 0, 2)); // exact touch
    pending_pairs.push_back(make_pair(0, 0, 9, 9, 0, 3, 4, -9, 7, 100));       // massless first
    pending_pairs.push_back(make_pair(0, 0, 9, 9, 100, 3, -4, -9, 7, 0));      // massless second
    pending_pairs.push_back(make_pair(mn, mn, mx, mn, rmax, mx, mx, mn, mx, rmax)); // d2 overflow
    pending_pairs.push_back(make_pair(mx, mx, mx, mx, rmax, mx, mx - 1, mn, mn, rmax));
    pending_pairs.push_back(make_pair(mn, mn, mn, mn, rmax, mn + 1, mn, mx, mx, rmax));
    pending_pairs.push_back(make_pair(mx, 0, mn, 0, rmax, mx - 5, 0, mx, 0, rmax)); // saturate
    pending_pairs.push_back(make_pair(0, 0, mx, mx, rmax, -1, -1, mn, mn, 1));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, rmax, 0, 0, 0, 0, rmax));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, rmax, 0, 65536, 0, 0, 0));
    // random part, mostly pairs in or near contact
    for (int i = 0; i < N_RANDOM; i++) begin
      p = ($urandom_range(0, 4) == 0) ? wild_pair() : near_pair();
      if (i == 500) p.drain_first = 1;
      pending_pairs.push_back(p);
    end
    stim_done = 1;
  end

  // reset and end of run
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (stim_done && pending_pairs.size() == 0 && !have_pair && !in_valid &&
          expected_pairs.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_pairs.size() == 0 && n_out == n_in) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // beats, checking and watchdog at the rising edge
  always @(posedge clk) begin
    resolved_t e;
    logic signed [31:0] got [8];
    in_beat  = rst_n && in_valid && !in_stall;
    out_beat = rst_n && out_valid && !out_stall;
    if (in_beat) begin
      expected_pairs.push_back(resolve_pair(cur_pair));
      n_in++;
    end
    if (out_beat) begin
      n_out++;
      got = '{out_new_first_pos_x, out_new_first_pos_y, out_new_first_vel_x,
              out_new_first_vel_y, out_new_second_pos_x, out_new_second_pos_y,
              out_new_second_vel_x, out_new_second_vel_y};
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result beat", $time);
        errors++;
      end else begin
        e = expected_pairs.pop_front();
        foreach (got[i])
          if (got[i] !== e.v[i]) begin
            $display("%0t: field %0d expected %0d actual %0d", $time, i, e.v[i], got[i]);
            errors++;
          end
        if (out_contact_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_contact_status);
          errors++;
        end
      end
    end
    idle_cycles = (in_beat || out_beat) ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_beat) begin
        have_pair = 0;
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (!have_pair) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() != 0 &&
                     (!pending_pairs[0].drain_first || expected_pairs.size() == 0)) begin
          cur_pair = pending_pairs.pop_front();
          have_pair = 1;
          in_valid <= 1'b1;
          in_first_pos_x  <= cur_pair.apx; in_first_pos_y  <= cur_pair.apy;
          in_first_vel_x  <= cur_pair.avx; in_first_vel_y  <= cur_pair.avy;
          in_first_radius <= cur_pair.ra;
          in_second_pos_x <= cur_pair.bpx; in_second_pos_y <= cur_pair.bpy;
          in_second_vel_x <= cur_pair.bvx; in_second_vel_y <= cur_pair.bvy;
          in_second_radius <= cur_pair.rb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off to fill the pipeline
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && n_in >= 250) begin
        hold_done = 1;
        hold_cycles = 300;
      end
      if (out_beat) recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      else if (recv_gap > 0) recv_gap--;
      if (hold_cycles > 0) hold_cycles--;
      out_stall <= (recv_gap != 0) || (hold_cycles != 0);
    end
  end
endmodule
